// ===== rtl/core/msqb_pkg.sv =====
// Shared types, codes and defaults of the message slot queue bundler.
`default_nettype none

package msqb_pkg;

    localparam int SLOTS_DEFAULT       = 8;
    localparam int FRAME_BYTES_DEFAULT = 32;

    localparam logic [7:0] FWD_ID_LOW  = 8'h28;
    localparam logic [7:0] FWD_ID_HIGH = 8'h2F;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FRAME  = 1'b1;

    typedef enum logic [2:0] {
        STAT_ACCEPTED  = 3'd0,
        STAT_FORWARDED = 3'd1,
        STAT_TOO_LONG  = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_DROPPED   = 3'd4
    } status_t;

    typedef struct packed {
        logic       kind;
        status_t    status;
        logic [7:0] frame_byte;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/message_slot_queue_bundler.sv =====
// Top level of the message slot queue bundler: control, slot RAM and output register.
`default_nettype none

// A ring of SLOTS message slots of FRAME_BYTES bytes each lives in one single-port
// RAM. A begin word's status word is emitted once the output register is free, and
// an accepted begin writes its length byte through the one RAM port as it is taken
// and its tag byte in ST_TAG. A payload word writes one byte. A bundle read is
// accepted, then FRAME_BYTES frame words follow at one per cycle when the output is
// taken, then the frame closes, with a gap in ST_LEN when a waiting message does not
// fit. Each length and payload read is issued ahead of the state that uses its byte,
// so the registered RAM read leaves no gap. The slot RAM needs no clearing after reset.
module message_slot_queue_bundler #(
    parameter int SLOTS       = msqb_pkg::SLOTS_DEFAULT,
    parameter int FRAME_BYTES = msqb_pkg::FRAME_BYTES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // msg_id[7:0], msg_size[15:8], data_byte[23:16]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // status[2:0], frame_byte[10:3], zero[15:11]
    output logic             m_tuser,   // kind[0]
    output logic             m_tlast
);

    localparam int DEPTH = SLOTS * FRAME_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic           out_valid_reg;
    msqb_pkg::res_t out_res_reg;
    logic           out_free;
    logic           emit_valid;
    msqb_pkg::res_t emit;
    logic           ram_we;
    logic           ram_re;
    logic [AW-1:0]  ram_addr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;

    assign out_free = !out_valid_reg || m_tready;

    msqb_engine #(
        .SLOTS       (SLOTS),
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_op       (s_tuser),
        .s_id       (s_tdata[7:0]),
        .s_size     (s_tdata[15:8]),
        .s_byte     (s_tdata[23:16]),
        .out_free   (out_free),
        .emit_valid (emit_valid),
        .emit       (emit),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata)
    );

    msqb_slot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            out_res_reg <= emit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg.frame_byte, out_res_reg.status};
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last;

endmodule

`default_nettype wire

// ===== rtl/core/msqb_slot_ram.sv =====
// Single-port slot RAM with a registered read port.
`default_nettype none

module msqb_slot_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/msqb_engine.sv =====
// Queue control: slot reservation, payload fill and bundle frame sequencing.
`default_nettype none

module msqb_engine #(
    parameter int SLOTS       = msqb_pkg::SLOTS_DEFAULT,
    parameter int FRAME_BYTES = msqb_pkg::FRAME_BYTES_DEFAULT,
    parameter int AW          = $clog2(SLOTS * FRAME_BYTES)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_op,
    input  wire logic [7:0]    s_id,
    input  wire logic [7:0]    s_size,
    input  wire logic [7:0]    s_byte,
    input  wire logic          out_free,
    output logic               emit_valid,
    output msqb_pkg::res_t     emit,
    output logic               ram_we,
    output logic               ram_re,
    output logic [AW-1:0]      ram_addr,
    output logic [7:0]         ram_wdata,
    input  wire logic [7:0]    ram_rdata
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = $clog2(FRAME_BYTES);
    localparam int UW = $clog2(FRAME_BYTES + 1);
    localparam logic [AW-1:0] FB_A  = AW'(FRAME_BYTES);
    localparam logic [8:0]    FB_9  = 9'(FRAME_BYTES);
    localparam logic [UW-1:0] USED_FULL = UW'(FRAME_BYTES);
    localparam logic [UW-1:0] USED_LAST = UW'(FRAME_BYTES - 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TAG  = 5'b00010,
        ST_LEN  = 5'b00100,
        ST_COPY = 5'b01000,
        ST_PAD  = 5'b10000
    } state_t;

    state_t            state_reg,     state_next;
    logic              stat_pend_reg, stat_pend_next;
    msqb_pkg::status_t stat_code_reg, stat_code_next;
    logic [SLOTS-1:0]  ready_reg,     ready_next;
    logic [SW-1:0]     enter_reg,     enter_next;
    logic [SW-1:0]     exit_reg,      exit_next;
    logic [SW-1:0]     cur_slot_reg,  cur_slot_next;
    logic [SW-1:0]     fill_slot_reg, fill_slot_next;
    logic [PW-1:0]     fill_pos_reg,  fill_pos_next;
    logic [PW-1:0]     fill_left_reg, fill_left_next;
    logic              filling_reg,   filling_next;
    logic [7:0]        tag_reg,       tag_next;
    logic [SW-1:0]     tag_slot_reg,  tag_slot_next;
    logic [UW-1:0]     used_reg,      used_next;
    logic [PW-1:0]     rem_reg,       rem_next;
    logic [PW-1:0]     pos_reg,       pos_next;

    logic accept;
    logic fits;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        slot_inc = (s == SLOT_LAST) ? '0 : s + SW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
                                                input logic [PW-1:0] off);
        slot_addr = AW'(s) * FB_A + AW'(off);
    endfunction

    assign s_ready = (state_reg == ST_IDLE) && !stat_pend_reg;
    assign accept  = s_valid && s_ready;
    assign fits    = ({1'b0, ram_rdata} + 9'd1) <= (FB_9 - 9'(used_reg));

    always_comb
    begin
        state_next     = state_reg;
        stat_pend_next = stat_pend_reg;
        stat_code_next = stat_code_reg;
        ready_next     = ready_reg;
        enter_next     = enter_reg;
        exit_next      = exit_reg;
        cur_slot_next  = cur_slot_reg;
        fill_slot_next = fill_slot_reg;
        fill_pos_next  = fill_pos_reg;
        fill_left_next = fill_left_reg;
        filling_next   = filling_reg;
        tag_next       = tag_reg;
        tag_slot_next  = tag_slot_reg;
        used_next      = used_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = '0;
        ram_wdata      = '0;
        emit_valid     = 1'b0;
        emit           = '0;

        if (stat_pend_reg && out_free)
        begin
            emit_valid     = 1'b1;
            emit.kind      = msqb_pkg::KIND_STATUS;
            emit.status    = stat_code_reg;
            stat_pend_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_op)
                        msqb_pkg::OP_BEGIN:
                        begin
                            stat_pend_next = 1'b1;
                            if (s_id >= msqb_pkg::FWD_ID_LOW && s_id <= msqb_pkg::FWD_ID_HIGH)
                            begin
                                stat_code_next = msqb_pkg::STAT_FORWARDED;
                            end
                            else if (({1'b0, s_size} + 9'd2) > FB_9)
                            begin
                                stat_code_next = msqb_pkg::STAT_TOO_LONG;
                            end
                            else if (s_id == 8'd0)
                            begin
                                stat_code_next = msqb_pkg::STAT_DROPPED;
                            end
                            else if (filling_reg || ready_reg[enter_reg])
                            begin
                                stat_code_next = msqb_pkg::STAT_FULL;
                            end
                            else
                            begin
                                stat_code_next = msqb_pkg::STAT_ACCEPTED;
                                ram_we         = 1'b1;
                                ram_addr       = slot_addr(enter_reg, '0);
                                ram_wdata      = s_size + 8'd1;
                                tag_next       = s_id;
                                tag_slot_next  = enter_reg;
                                if (s_size == 8'd0)
                                begin
                                    ready_next[enter_reg] = 1'b1;
                                end
                                else
                                begin
                                    fill_slot_next = enter_reg;
                                    fill_pos_next  = PW'(2);
                                    fill_left_next = s_size[PW-1:0];
                                    filling_next   = 1'b1;
                                end
                                enter_next = slot_inc(enter_reg);
                                state_next = ST_TAG;
                            end
                        end
                        msqb_pkg::OP_DATA:
                        begin
                            if (filling_reg)
                            begin
                                ram_we         = 1'b1;
                                ram_addr       = slot_addr(fill_slot_reg, fill_pos_reg);
                                ram_wdata      = s_byte;
                                fill_pos_next  = fill_pos_reg + PW'(1);
                                fill_left_next = fill_left_reg - PW'(1);
                                if (fill_left_reg == PW'(1))
                                begin
                                    filling_next              = 1'b0;
                                    ready_next[fill_slot_reg] = 1'b1;
                                end
                            end
                        end
                        msqb_pkg::OP_READ:
                        begin
                            used_next = '0;
                            if (ready_reg[exit_reg])
                            begin
                                ram_re     = 1'b1;
                                ram_addr   = slot_addr(exit_reg, '0);
                                state_next = ST_LEN;
                            end
                            else
                            begin
                                state_next = ST_PAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TAG:
            begin
                ram_we     = 1'b1;
                ram_addr   = slot_addr(tag_slot_reg, PW'(1));
                ram_wdata  = tag_reg;
                state_next = ST_IDLE;
            end
            ST_LEN:
            begin
                if (!fits)
                begin
                    state_next = ST_PAD;
                end
                else if (out_free)
                begin
                    emit_valid           = 1'b1;
                    emit.kind            = msqb_pkg::KIND_FRAME;
                    emit.frame_byte      = ram_rdata;
                    emit.last            = (used_reg == USED_LAST);
                    used_next            = used_reg + UW'(1);
                    rem_next             = ram_rdata[PW-1:0];
                    pos_next             = PW'(1);
                    ram_re               = 1'b1;
                    ram_addr             = slot_addr(exit_reg, PW'(1));
                    ready_next[exit_reg] = 1'b0;
                    cur_slot_next        = exit_reg;
                    exit_next            = slot_inc(exit_reg);
                    state_next           = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (out_free)
                begin
                    emit_valid      = 1'b1;
                    emit.kind       = msqb_pkg::KIND_FRAME;
                    emit.frame_byte = ram_rdata;
                    emit.last       = (used_reg == USED_LAST);
                    used_next       = used_reg + UW'(1);
                    if (rem_reg == PW'(1))
                    begin
                        if (ready_reg[exit_reg])
                        begin
                            ram_re     = 1'b1;
                            ram_addr   = slot_addr(exit_reg, '0);
                            state_next = ST_LEN;
                        end
                        else
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else
                    begin
                        rem_next = rem_reg - PW'(1);
                        pos_next = pos_reg + PW'(1);
                        ram_re   = 1'b1;
                        ram_addr = slot_addr(cur_slot_reg, pos_reg + PW'(1));
                    end
                end
            end
            ST_PAD:
            begin
                if (used_reg == USED_FULL)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit_valid      = 1'b1;
                    emit.kind       = msqb_pkg::KIND_FRAME;
                    emit.frame_byte = 8'd0;
                    emit.last       = (used_reg == USED_LAST);
                    used_next       = used_reg + UW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stat_pend_reg <= 1'b0;
            ready_reg     <= '0;
            enter_reg     <= '0;
            exit_reg      <= '0;
            fill_slot_reg <= '0;
            fill_pos_reg  <= '0;
            fill_left_reg <= '0;
            filling_reg   <= 1'b0;
            used_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            stat_pend_reg <= stat_pend_next;
            ready_reg     <= ready_next;
            enter_reg     <= enter_next;
            exit_reg      <= exit_next;
            fill_slot_reg <= fill_slot_next;
            fill_pos_reg  <= fill_pos_next;
            fill_left_reg <= fill_left_next;
            filling_reg   <= filling_next;
            used_reg      <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_code_reg <= stat_code_next;
        cur_slot_reg  <= cur_slot_next;
        tag_reg       <= tag_next;
        tag_slot_reg  <= tag_slot_next;
        rem_reg       <= rem_next;
        pos_reg       <= pos_next;
    end

endmodule

`default_nettype wire

// ===== bench/bundler_checker.sv =====
// Checker that predicts and compares every output word of the message slot queue bundler.
`timescale 1ns / 1ps

module bundler_checker #(
    parameter int SLOTS       = msqb_pkg::SLOTS_DEFAULT,
    parameter int FRAME_BYTES = msqb_pkg::FRAME_BYTES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // msg_id[7:0], msg_size[15:8], data_byte[23:16]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // status[2:0], frame_byte[10:3], zero[15:11]
    input  wire logic        m_tuser,   // kind[0]
    input  wire logic        m_tlast,
    output int               errors,
    output int               outstanding,
    output int               statuses_seen,
    output int               frames_seen
);

    logic [7:0]  slot_mem [SLOTS * FRAME_BYTES];
    logic        slot_ready [SLOTS] = '{default: 1'b0};
    int unsigned enter_ptr = 0;
    int unsigned exit_ptr  = 0;
    int unsigned fill_slot = 0;
    int unsigned fill_pos  = 0;
    int unsigned fill_left = 0;
    bit          filling   = 1'b0;

    msqb_pkg::res_t awaited_words [$];
    int   mismatches = 0;
    int   status_count = 0;
    int   frame_count = 0;

    task automatic flag_mismatch(input string what);
        $display("checker: mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic apply_slot_word(input logic [1:0] op, input logic [7:0] id,
                                   input logic [7:0] size, input logic [7:0] dbyte);
        int unsigned       base;
        int unsigned       total;
        int unsigned       used;
        logic [7:0]        frame [FRAME_BYTES];
        msqb_pkg::res_t    word;
        msqb_pkg::status_t verdict;

        case (op)
            msqb_pkg::OP_BEGIN:
            begin
                if (id >= msqb_pkg::FWD_ID_LOW && id <= msqb_pkg::FWD_ID_HIGH)
                    verdict = msqb_pkg::STAT_FORWARDED;
                else if (int'(size) + 2 > FRAME_BYTES)
                    verdict = msqb_pkg::STAT_TOO_LONG;
                else if (id == 8'h00)
                    verdict = msqb_pkg::STAT_DROPPED;
                else if (filling || slot_ready[enter_ptr])
                    verdict = msqb_pkg::STAT_FULL;
                else
                begin
                    verdict = msqb_pkg::STAT_ACCEPTED;
                    base = enter_ptr * FRAME_BYTES;
                    slot_mem[base]     = size + 8'd1;
                    slot_mem[base + 1] = id;
                    if (size == 8'h00)
                    begin
                        slot_ready[enter_ptr] = 1'b1;
                    end
                    else
                    begin
                        fill_slot = enter_ptr;
                        fill_pos  = 2;
                        fill_left = 32'(size);
                        filling   = 1'b1;
                    end
                    enter_ptr = (enter_ptr + 1) % SLOTS;
                end
                word.kind       = msqb_pkg::KIND_STATUS;
                word.status     = verdict;
                word.frame_byte = 8'h00;
                word.last       = 1'b0;
                awaited_words.push_back(word);
            end
            msqb_pkg::OP_DATA:
            begin
                if (filling)
                begin
                    if (fill_pos < FRAME_BYTES)
                        slot_mem[fill_slot * FRAME_BYTES + fill_pos] = dbyte;
                    fill_pos++;
                    fill_left--;
                    if (fill_left == 0)
                    begin
                        filling = 1'b0;
                        slot_ready[fill_slot] = 1'b1;
                    end
                end
            end
            msqb_pkg::OP_READ:
            begin
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    frame[i] = 8'h00;
                end
                used = 0;
                while (slot_ready[exit_ptr])
                begin
                    base  = exit_ptr * FRAME_BYTES;
                    total = int'(slot_mem[base]) + 1;
                    if (total > FRAME_BYTES - used)
                        break;
                    for (int i = 0; i < total; i++)
                    begin
                        frame[used + i] = slot_mem[base + i];
                    end
                    used += total;
                    slot_ready[exit_ptr] = 1'b0;
                    exit_ptr = (exit_ptr + 1) % SLOTS;
                end
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    word.kind       = msqb_pkg::KIND_FRAME;
                    word.status     = msqb_pkg::STAT_ACCEPTED;
                    word.frame_byte = frame[i];
                    word.last       = (i == FRAME_BYTES - 1);
                    awaited_words.push_back(word);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_out_word();
        msqb_pkg::res_t want;

        if (awaited_words.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected word tdata=%h tuser=%b tlast=%b",
                                    m_tdata, m_tuser, m_tlast));
        end
        else
        begin
            want = awaited_words.pop_front();
            if (m_tuser !== want.kind)
                flag_mismatch($sformatf("kind %b, want %b", m_tuser, want.kind));
            if (m_tdata[2:0] !== want.status)
                flag_mismatch($sformatf("status %0d, want %0d", m_tdata[2:0], want.status));
            if (m_tdata[10:3] !== want.frame_byte)
                flag_mismatch($sformatf("frame byte %h, want %h", m_tdata[10:3],
                                        want.frame_byte));
            if (m_tlast !== want.last)
                flag_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
            if (m_tdata[15:11] !== 5'd0)
                flag_mismatch($sformatf("padding bits %b are not zero", m_tdata[15:11]));
            if (want.kind == msqb_pkg::KIND_STATUS)
                status_count++;
            else if (want.last)
                frame_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                apply_slot_word(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
            if (m_tvalid && m_tready)
                compare_out_word();
        end
        errors        <= mismatches;
        outstanding   <= awaited_words.size();
        statuses_seen <= status_count;
        frames_seen   <= frame_count;
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the bench: clock, reset, stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int         SLOTS        = msqb_pkg::SLOTS_DEFAULT;
    localparam int         FRAME_BYTES  = msqb_pkg::FRAME_BYTES_DEFAULT;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_WORDS = 140;
    localparam int         LONG_HOLD    = 400;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES = 40;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = 24'd0;
    logic [1:0]  s_tuser  = msqb_pkg::OP_BEGIN;
    logic        m_tready = 1'b0;
    wire logic   s_tready;
    wire logic   m_tvalid;
    wire logic [15:0] m_tdata;
    wire logic   m_tuser;
    wire logic   m_tlast;

    int errors;
    int outstanding;
    int statuses_seen;
    int frames_seen;

    int       burst_left  = 0;
    int       words_sent  = 0;
    logic     hold_kick   = 1'b0;
    bit       hold_taken  = 1'b0;
    int       hold_left   = 0;
    int       rx_cycle    = 0;
    rx_mode_t rx_mode     = RX_OPEN;

    message_slot_queue_bundler uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    bundler_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .errors        (errors),
        .outstanding   (outstanding),
        .statuses_seen (statuses_seen),
        .frames_seen   (frames_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic push_word(input logic [1:0] op, input logic [7:0] id,
                             input logic [7:0] size, input logic [7:0] dbyte);
        int gap;

        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {dbyte, size, id};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        words_sent++;
    endtask

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_kick && !hold_taken)
        begin
            m_tready   <= 1'b0;
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
        end
        else
        begin
            case (rx_mode)
                RX_OPEN:     m_tready <= 1'b1;
                RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_tready <= (rx_cycle % 4 != 3);
                default:     m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int pick;
        int size;
        int count;
        int useful;
        int directed;
        logic [7:0] id;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner cases on an empty queue, then the status checks in their priority order.
        push_word(msqb_pkg::OP_READ, 8'hFF, 8'hFF, 8'hFF);
        push_word(msqb_pkg::OP_DATA, 8'h00, 8'h00, 8'hA5);
        push_word(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF);
        push_word(msqb_pkg::OP_BEGIN, msqb_pkg::FWD_ID_LOW, 8'd3, 8'h00);
        push_word(msqb_pkg::OP_BEGIN, msqb_pkg::FWD_ID_HIGH, 8'd200, 8'hFF);
        push_word(msqb_pkg::OP_BEGIN, 8'h30, 8'(FRAME_BYTES - 1), 8'h00);
        push_word(msqb_pkg::OP_BEGIN, 8'h00, 8'hFF, 8'h00);
        push_word(msqb_pkg::OP_BEGIN, 8'h00, 8'd4, 8'h00);
        push_word(msqb_pkg::OP_BEGIN, 8'hFF, 8'd0, 8'h00);
        push_word(msqb_pkg::OP_BEGIN, 8'h01, 8'd2, 8'h00);
        push_word(msqb_pkg::OP_BEGIN, 8'h02, 8'd1, 8'h00);
        push_word(msqb_pkg::OP_DATA, 8'hFF, 8'hFF, 8'hFF);
        push_word(msqb_pkg::OP_DATA, 8'hFF, 8'hFF, 8'h00);
        push_word(msqb_pkg::OP_READ, 8'h00, 8'h00, 8'h00);
        // Fill every slot with empty messages so that the next begin finds the ring full.
        for (int i = 0; i < SLOTS; i++)
        begin
            push_word(msqb_pkg::OP_BEGIN, 8'(8'h10 + i), 8'd0, 8'h00);
        end
        push_word(msqb_pkg::OP_BEGIN, 8'h55, 8'd0, 8'h00);
        push_word(msqb_pkg::OP_READ, 8'h00, 8'h00, 8'h00);
        push_word(msqb_pkg::OP_READ, 8'h00, 8'h00, 8'h00);
        directed = words_sent;

        useful = 0;
        while (useful < RANDOM_WORDS)
        begin
            if (useful >= 60)
                hold_kick <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(20, FRAME_BYTES - 2)
                                                   : $urandom_range(0, 6);
                count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, size) : size;
                push_word(msqb_pkg::OP_BEGIN, 8'($urandom_range(1, 255)), 8'(size),
                          8'($urandom_range(0, 255)));
                for (int i = 0; i < count; i++)
                begin
                    push_word(msqb_pkg::OP_DATA, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
                useful += 1 + count;
            end
            else if (pick < 72)
            begin
                push_word(msqb_pkg::OP_READ, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                useful++;
            end
            else if (pick < 82)
            begin
                case ($urandom_range(0, 2))
                    0:       id = 8'h00;
                    1:       id = 8'($urandom_range(msqb_pkg::FWD_ID_LOW,
                                                    msqb_pkg::FWD_ID_HIGH));
                    default: id = 8'($urandom_range(0, 255));
                endcase
                push_word(msqb_pkg::OP_BEGIN, id, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
                useful++;
            end
            else if (pick < 90)
            begin
                push_word(msqb_pkg::OP_DATA, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            else if (pick < 95)
            begin
                push_word(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end
            else
            begin
                push_word(msqb_pkg::OP_BEGIN, 8'($urandom_range(0, 255)), 8'd0,
                          8'($urandom_range(0, 255)));
                useful++;
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("testbench: %0d input words (%0d directed), %0d status words, %0d frames.",
                 words_sent, directed, statuses_seen, frames_seen);
        $display("testbench: bursty sender, four receiver stall modes, one %0d-cycle hold.",
                 LONG_HOLD);
        if (errors == 0 && outstanding == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
